@@ rtl/srgb_to_cielab_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sRGB to CIELAB unit.
// ----------------------------------------------------------------------------
`ifndef SRGB_TO_CIELAB_UNIT_ASSERT_SVH
`define SRGB_TO_CIELAB_UNIT_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define SCU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define SCU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/scu_pkg.sv @@
// ----------------------------------------------------------------------------
// scu_pkg
// Types, constants and the gamma decoding table of the sRGB to CIELAB unit.
// ----------------------------------------------------------------------------
package scu_pkg;

  // Internal fixed point: unsigned values scaled by 2^30.
  localparam int QB = 30;

  typedef logic [30:0] q30_t;
  typedef q30_t lut_t [256];

  // Lab curve pipeline entry: cube root search and linear branch quotient.
  typedef struct packed {
    logic [30:0] t;
    logic        big;
    logic [30:0] r;
    logic [30:0] cand;
    logic [31:0] sq;
    logic [39:0] lnum;
    logic [39:0] lprod;
    logic [30:0] lq;
  } lab_t;

  // Divisors of the matrix rows (X, Y, Z) and of the linear Lab branch.
  localparam logic [16:0] XYZ_DIVISOR [3] = '{17'd95047, 17'd10000, 17'd108883};
  localparam logic [10:0] LIN_DIVISOR = 11'd1160;

  // Matrix row numerators (X and Z scaled by ten) and their rounding offsets.
  localparam logic [16:0] MAT_COEF [3][3] = '{
    '{17'd41240, 17'd35760, 17'd18050},
    '{17'd2126,  17'd7152,  17'd722},
    '{17'd1930,  17'd11920, 17'd95050}
  };
  localparam logic [16:0] MAT_OFFSET [3] = '{17'd47523, 17'd5000, 17'd54441};

  // Reciprocal scaling of the quotient estimates.
  localparam int RECIP_SH = 32;
  localparam int LIN_SH   = 28;

  // Coefficient over divisor, scaled by 2^32 and rounded down.
  function automatic logic [31:0] mat_recip(input int row, input int col);
    return 32'((64'(MAT_COEF[row][col]) << RECIP_SH) / 64'(XYZ_DIVISOR[row]));
  endfunction

  function automatic logic [31:0] mat_offset_recip(input int row);
    return 32'((64'(MAT_OFFSET[row]) << RECIP_SH) / 64'(XYZ_DIVISOR[row]));
  endfunction

  // Rounded-down reciprocals keep every estimate at most one below the quotient.
  localparam logic [31:0] MAT_RECIP [3][3] = '{
    '{mat_recip(0, 0), mat_recip(0, 1), mat_recip(0, 2)},
    '{mat_recip(1, 0), mat_recip(1, 1), mat_recip(1, 2)},
    '{mat_recip(2, 0), mat_recip(2, 1), mat_recip(2, 2)}
  };
  localparam logic [31:0] MAT_OFFSET_RECIP [3] = '{
    mat_offset_recip(0), mat_offset_recip(1), mat_offset_recip(2)
  };

  // Linear Lab branch: (9033 t + 160 * 2^30 + 580) / 1160.
  localparam logic [13:0] LIN_SCALE  = 14'd9033;
  localparam logic [39:0] LIN_OFFSET = (40'd160 << QB) + 40'd580;
  localparam logic [31:0] LIN_RECIP  =
    32'((64'(LIN_SCALE) << LIN_SH) / 64'(LIN_DIVISOR));
  localparam logic [63:0] LIN_OFFSET_RECIP =
    64'((96'(LIN_OFFSET) << LIN_SH) / 96'(LIN_DIVISOR));

  // Fixed point product, truncated.
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> QB;
  endfunction

  function automatic logic [63:0] pow5_q(input logic [63:0] r);
    logic [63:0] p;
    p = qmul(r, r);
    p = qmul(p, r);
    p = qmul(p, r);
    return qmul(p, r);
  endfunction

  // Linear light of one gamma encoded code.
  function automatic logic [63:0] decode_code(input logic [63:0] c);
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    if (c <= 64'd10) begin
      return (c * 64'd10 * (64'd1 << QB) + 64'd16473) / 64'd32946;
    end
    x  = ((64'd1000 * c + 64'd14025) << QB) / 64'd269025;
    s  = qmul(x, x);
    lo = 64'd0;
    hi = 64'd1 << QB;
    for (int i = 0; i < 32; i++) begin
      if (lo < hi) begin
        mid = lo + (hi - lo + 64'd1) / 64'd2;
        if (pow5_q(mid) <= s) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return qmul(s, lo);
  endfunction

  function automatic lut_t build_decode_lut();
    lut_t lut;
    logic [63:0] v;
    for (int c = 0; c < 256; c++) begin
      v = decode_code(64'(c));
      lut[c] = v[30:0];
    end
    return lut;
  endfunction

  localparam lut_t DECODE_LUT = build_decode_lut();

endpackage

@@ rtl/srgb_to_cielab_unit.sv @@
// ----------------------------------------------------------------------------
// srgb_to_cielab_unit
// Converts one 8-bit sRGB pixel per cycle into CIELAB (D65 white).
//
// The pixel channel (pixel_valid, pixel_ready, red, green, blue) takes one
// request per cycle. The Lab channel (lab_valid, lab_ready, lightness,
// green_red, blue_yellow) returns one result per request, in order.
// Results carry FRAC_BITS fraction bits; a and b saturate at 16 bits.
// The pipeline has 69 register stages: a table stage, a matrix stage, a
// quotient product stage, a quotient correction stage, a curve entry stage,
// 62 cube root stages (31 search bits, one multiplier stage each for square
// and cube) and two output stages. Throughput is one pixel per cycle.
// The whole pipeline advances together whenever the output register is
// empty or is being taken; while the receiver stalls a full result, the
// pipeline holds and pixel_ready is low, and nothing is lost or repeated.
// Reset clears every valid bit; the datapath holds no other state.
// ----------------------------------------------------------------------------
module srgb_to_cielab_unit
  import scu_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  output logic               lab_valid,
  input  logic               lab_ready,
  output logic [14:0]        lightness,
  output logic signed [15:0] green_red,
  output logic signed [15:0] blue_yellow
);

  localparam int OUT_SHIFT = QB - FRAC_BITS;
  localparam int LAB_STEPS = 62;
  localparam int NSTAGE    = LAB_STEPS + 7;
  localparam logic [41:0] HALF = 42'd1 << (OUT_SHIFT - 1);

  logic [NSTAGE-1:0] vld;
  logic              adv;

  q30_t              lin [3];
  q30_t              lin_next [3];
  logic [47:0]       num [3];
  logic [47:0]       num_next [3];
  q30_t              est [3];
  q30_t              est_next [3];
  logic [47:0]       num_d [3];
  logic [47:0]       num_d_next [3];
  q30_t              est_d [3];
  q30_t              est_d_next [3];
  logic [47:0]       prod [3];
  logic [47:0]       prod_next [3];
  q30_t              tq [3];
  q30_t              tq_next [3];
  lab_t              lab [3][LAB_STEPS+1];
  lab_t              lab_next [3][LAB_STEPS+1];
  logic [39:0]       lraw;
  logic [39:0]       lraw_next;
  logic [41:0]       araw;
  logic [41:0]       araw_next;
  logic [41:0]       braw;
  logic [41:0]       braw_next;
  logic [14:0]       lightness_next;
  logic [15:0]       green_red_next;
  logic [15:0]       blue_yellow_next;

  // Rounds a signed value on its magnitude and saturates it to 16 bits.
  function automatic logic [15:0] round_sat(input logic [41:0] v);
    logic        neg;
    logic [41:0] mag;
    logic [41:0] rq;
    neg = v[41];
    mag = neg ? (42'd0 - v) : v;
    rq  = (mag + HALF) >> OUT_SHIFT;
    if (!neg) begin
      return (rq > 42'd32767) ? 16'h7fff : rq[15:0];
    end
    return (rq > 42'd32768) ? 16'h8000 : (16'd0 - rq[15:0]);
  endfunction

  // The pipeline moves as one whenever the output register can take a result.
  assign adv         = lab_ready || !vld[NSTAGE-1];
  assign pixel_ready = adv;
  assign lab_valid   = vld[NSTAGE-1];

  // Next values of every stage.
  always_comb begin
    logic [63:0] esum;
    logic [63:0] lsum;
    logic [47:0] rem;
    logic [39:0] lrem;
    logic [61:0] sqp;
    logic [62:0] cup;
    q30_t        tv;
    q30_t        fsel [3];

    // Gamma decoding through the constant table.
    lin_next[0] = DECODE_LUT[red];
    lin_next[1] = DECODE_LUT[green];
    lin_next[2] = DECODE_LUT[blue];

    // Matrix rows with rounding offsets, and a reciprocal quotient estimate
    // that is either exact or one low.
    for (int c = 0; c < 3; c++) begin
      num_next[c] = 48'(lin[0]) * 48'(MAT_COEF[c][0]) + 48'(lin[1]) * 48'(MAT_COEF[c][1])
                  + 48'(lin[2]) * 48'(MAT_COEF[c][2]) + 48'(MAT_OFFSET[c]);
      esum = 64'(lin[0]) * 64'(MAT_RECIP[c][0]) + 64'(lin[1]) * 64'(MAT_RECIP[c][1])
           + 64'(lin[2]) * 64'(MAT_RECIP[c][2]) + 64'(MAT_OFFSET_RECIP[c]);
      est_next[c] = 31'(esum >> RECIP_SH);
    end

    // Product of the estimate and the white point divisor.
    for (int c = 0; c < 3; c++) begin
      num_d_next[c] = num[c];
      est_d_next[c] = est[c];
      prod_next[c]  = 48'(est[c]) * 48'(XYZ_DIVISOR[c]);
    end

    // A remainder of one divisor or more means the estimate was one low.
    for (int c = 0; c < 3; c++) begin
      rem = num_d[c] - prod[c];
      tq_next[c] = (rem >= 48'(XYZ_DIVISOR[c])) ? est_d[c] + 31'd1 : est_d[c];
    end

    // Lab curve entry: branch select and linear branch estimate. Below the
    // knee t stays under 2^24, so only its low bits feed the linear branch.
    for (int c = 0; c < 3; c++) begin
      tv = tq[c];
      lab_next[c][0].t     = tv;
      lab_next[c][0].big   = (52'(tv) * 52'd1000000) > (52'd8856 << QB);
      lab_next[c][0].r     = '0;
      lab_next[c][0].cand  = '0;
      lab_next[c][0].sq    = '0;
      lab_next[c][0].lnum  = 40'(tv[23:0]) * 40'(LIN_SCALE) + LIN_OFFSET;
      lab_next[c][0].lprod = '0;
      lsum = 64'(tv[23:0]) * 64'(LIN_RECIP) + LIN_OFFSET_RECIP;
      lab_next[c][0].lq    = 31'(lsum >> LIN_SH);
    end

    // Cube root search, one bit per two stages, beside the linear correction.
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < LAB_STEPS; k++) begin
        lab_next[c][k+1] = lab[c][k];
        if (k == 0) begin
          lab_next[c][k+1].lprod = 40'(lab[c][k].lq) * 40'(LIN_DIVISOR);
        end
        if (k == 1) begin
          lrem = lab[c][k].lnum - lab[c][k].lprod;
          if (lrem >= 40'(LIN_DIVISOR)) begin
            lab_next[c][k+1].lq = lab[c][k].lq + 31'd1;
          end
        end
        if ((k % 2) == 0) begin
          lab_next[c][k+1].cand = lab[c][k].r | (31'd1 << (30 - k / 2));
          sqp = 62'(lab_next[c][k+1].cand) * 62'(lab_next[c][k+1].cand);
          lab_next[c][k+1].sq = sqp[61:30];
        end else begin
          cup = 63'(lab[c][k].sq) * 63'(lab[c][k].cand);
          if (cup[62:30] <= {2'b0, lab[c][k].t}) begin
            lab_next[c][k+1].r = lab[c][k].cand;
          end
        end
      end
    end

    // Select the curve branch and form the scaled Lab differences.
    for (int c = 0; c < 3; c++) begin
      fsel[c] = lab[c][LAB_STEPS].big ? lab[c][LAB_STEPS].r : lab[c][LAB_STEPS].lq;
    end
    lraw_next = 40'(fsel[1]) * 40'd116 - (40'd16 << QB);
    araw_next = (42'(fsel[0]) - 42'(fsel[1])) * 42'd500;
    braw_next = (42'(fsel[1]) - 42'(fsel[2])) * 42'd200;

    // Output rounding and saturation.
    if (lraw[39]) begin
      lightness_next = '0;
    end else if (((lraw + HALF[39:0]) >> OUT_SHIFT) > 40'd32767) begin
      lightness_next = 15'h7fff;
    end else begin
      lightness_next = 15'((lraw + HALF[39:0]) >> OUT_SHIFT);
    end
    green_red_next   = round_sat(araw);
    blue_yellow_next = round_sat(braw);
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTAGE-2:0], pixel_valid};
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      lin         <= lin_next;
      num         <= num_next;
      est         <= est_next;
      num_d       <= num_d_next;
      est_d       <= est_d_next;
      prod        <= prod_next;
      tq          <= tq_next;
      lab         <= lab_next;
      lraw        <= lraw_next;
      araw        <= araw_next;
      braw        <= braw_next;
      lightness   <= lightness_next;
      green_red   <= $signed(green_red_next);
      blue_yellow <= $signed(blue_yellow_next);
    end
  end

endmodule

@@ rtl/scu_checker.sv @@
// ----------------------------------------------------------------------------
// scu_checker
// Port level checks of the sRGB to CIELAB unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "srgb_to_cielab_unit_assert.svh"

module scu_checker #(
  parameter int FRAC_BITS = 8
) (
  input logic               clk,
  input logic               rst,
  input logic               pixel_valid,
  input logic               pixel_ready,
  input logic [7:0]         red,
  input logic [7:0]         green,
  input logic [7:0]         blue,
  input logic               lab_valid,
  input logic               lab_ready,
  input logic [14:0]        lightness,
  input logic signed [15:0] green_red,
  input logic signed [15:0] blue_yellow
);

  // A stalled result stays on the port unchanged.
  `SCU_ASSERT(a_hold, lab_valid && !lab_ready |=> lab_valid && $stable(lightness) && $stable(green_red) && $stable(blue_yellow), "stalled result changed")

  // Reset empties the pipeline.
  `SCU_ASSERT_RST(a_reset_empty, rst |=> !lab_valid, "result shown after reset")

  // With no result waiting the unit always takes a pixel request.
  `SCU_ASSERT(a_ready_when_empty, !lab_valid |-> pixel_ready, "request refused while output empty")

  // Lightness never exceeds one hundred.
  `SCU_ASSERT(a_light_range, lab_valid |-> (32'(lightness) <= (32'd100 << FRAC_BITS)), "lightness above 100")

endmodule

bind srgb_to_cielab_unit scu_checker #(.FRAC_BITS(FRAC_BITS)) u_scu_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed sRGB pixels into the sRGB to CIELAB unit and
// checks each Lab result against a bit-exact fixed point model kept here.
// ----------------------------------------------------------------------------
module testbench;
  import scu_pkg::*;

  localparam int FRAC = 8;
  localparam int SHIFT = 30 - FRAC;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  typedef struct {
    logic [14:0]        l;
    logic signed [15:0] a;
    logic signed [15:0] bb;
  } lab_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               pixel_valid = 1'b0;
  logic               pixel_ready;
  logic [7:0]         red = '0;
  logic [7:0]         green = '0;
  logic [7:0]         blue = '0;
  logic               lab_valid;
  logic               lab_ready = 1'b0;
  logic [14:0]        lightness;
  logic signed [15:0] green_red;
  logic signed [15:0] blue_yellow;

  pixel_t      pending_pixels[$];
  lab_res_t    expected_lab[$];
  logic [63:0] linear_table [256];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          cycle_no = 0;
  logic        pixel_taken = 1'b0;

  srgb_to_cielab_unit #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
    .red(red), .green(green), .blue(blue),
    .lab_valid(lab_valid), .lab_ready(lab_ready),
    .lightness(lightness), .green_red(green_red), .blue_yellow(blue_yellow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Truncating Q30 product.
  function automatic logic [63:0] fx_mul(input logic [63:0] p, input logic [63:0] q);
    return (p * q) >> 30;
  endfunction

  // Linear light of one gamma encoded code, in Q30.
  function automatic logic [63:0] gamma_to_linear(input logic [63:0] c);
    logic [63:0] x, s, lo, hi, mid, p;
    if (c <= 10) begin
      return (c * 64'd10 * (64'd1 << 30) + 64'd16473) / 64'd32946;
    end
    x = ((64'd1000 * c + 64'd14025) << 30) / 64'd269025;
    s = fx_mul(x, x);
    lo = 0;
    hi = 64'd1 << 30;
    // Fifth root of s by bisection, so that lin = s^(1.2).
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      p = fx_mul(fx_mul(fx_mul(fx_mul(mid, mid), mid), mid), mid);
      if (p <= s) lo = mid;
      else hi = mid - 1;
    end
    return fx_mul(s, lo);
  endfunction

  // CIELAB companding curve in Q30.
  function automatic logic [63:0] lab_curve_q(input logic [63:0] t);
    logic [63:0] lo, hi, mid;
    if (t * 64'd1000000 > (64'd8856 << 30)) begin
      lo = 0;
      hi = (64'd1 << 31) - 1;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (fx_mul(fx_mul(mid, mid), mid) <= t) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    end
    return (64'd9033 * t + (64'd160 << 30) + 64'd580) / 64'd1160;
  endfunction

  // Rounds half away from zero to the output fraction width.
  function automatic longint to_out_frac(input longint v);
    longint half;
    half = longint'(1) << (SHIFT - 1);
    if (v >= 0) return (v + half) >>> SHIFT;
    return -((-v + half) >>> SHIFT);
  endfunction

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic lab_res_t pixel_to_lab(input pixel_t px);
    logic [63:0] lr, lg, lb, x, y, z;
    longint      fx, fy, fz, lv, lq;
    lab_res_t    res;
    lr = linear_table[px.r];
    lg = linear_table[px.g];
    lb = linear_table[px.b];
    x = (64'd10 * (64'd4124 * lr + 64'd3576 * lg + 64'd1805 * lb) + 64'd47523) / 64'd95047;
    y = (64'd2126 * lr + 64'd7152 * lg + 64'd722 * lb + 64'd5000) / 64'd10000;
    z = (64'd10 * (64'd193 * lr + 64'd1192 * lg + 64'd9505 * lb) + 64'd54441) / 64'd108883;
    fx = longint'(lab_curve_q(x));
    fy = longint'(lab_curve_q(y));
    fz = longint'(lab_curve_q(z));
    lv = 116 * fy - (longint'(16) << 30);
    // A rounding dip below zero near black gives zero lightness.
    if (lv < 0) lv = 0;
    lq = to_out_frac(lv);
    if (lq > 32767) lq = 32767;
    res.l = 15'(lq);
    res.a = clamp16(to_out_frac(500 * (fx - fy)));
    res.bb = clamp16(to_out_frac(200 * (fy - fz)));
    return res;
  endfunction

  // Idling is suspended for a stretch in the middle of the run.
  function automatic logic take_turn();
    if (cycle_no > 500 && cycle_no < 900) return 1'b1;
    return $urandom_range(99) >= 35;
  endfunction

  // Request driver: a new pixel only once the previous one was taken.
  always @(negedge clk) begin
    pixel_t px;
    logic   nv;
    if (!rst && (!pixel_valid || pixel_taken)) begin
      nv = 1'b0;
      if (pending_pixels.size() > 0 && take_turn()) begin
        px = pending_pixels.pop_front();
        red <= px.r;
        green <= px.g;
        blue <= px.b;
        nv = 1'b1;
      end
      pixel_valid <= nv;
    end
    if (!rst) lab_ready <= take_turn();
  end

  // Monitor: records accepted requests and checks results in order.
  always @(posedge clk) begin
    pixel_t   px;
    lab_res_t want;
    cycle_no <= cycle_no + 1;
    pixel_taken <= pixel_valid && pixel_ready;
    if (!rst) begin
      if (pixel_valid && pixel_ready) begin
        px.r = red;
        px.g = green;
        px.b = blue;
        expected_lab.push_back(pixel_to_lab(px));
      end
      if (lab_valid && lab_ready) begin
        if (expected_lab.size() == 0) begin
          if (mismatches < 10) $display("Unexpected result L=%0d a=%0d b=%0d",
                                        lightness, green_red, blue_yellow);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_lab.pop_front();
          if (want.l !== lightness || want.a !== green_red || want.bb !== blue_yellow) begin
            if (mismatches < 10)
              $display("Mismatch: expected L=%0d a=%0d b=%0d, got L=%0d a=%0d b=%0d",
                       want.l, want.a, want.bb, lightness, green_red, blue_yellow);
            mismatches <= mismatches + 1;
          end
        end
      end
      // Watchdog on cycles with no handshake on either side.
      if ((pixel_valid && pixel_ready) || (lab_valid && lab_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic queue_pixel(input int r, input int g, input int b);
    pixel_t px;
    px.r = 8'(r);
    px.g = 8'(g);
    px.b = 8'(b);
    pending_pixels.push_back(px);
  endtask

  initial begin
    int sel;
    for (int c = 0; c < 256; c++) linear_table[c] = gamma_to_linear(64'(c));

    // Directed: extremes, primaries, near black and the decode knee.
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(255, 0, 0);
    queue_pixel(0, 255, 0);
    queue_pixel(0, 0, 255);
    queue_pixel(255, 255, 0);
    queue_pixel(0, 255, 255);
    queue_pixel(255, 0, 255);
    queue_pixel(1, 0, 0);
    queue_pixel(0, 0, 1);
    queue_pixel(1, 1, 1);
    queue_pixel(10, 10, 10);
    queue_pixel(11, 11, 11);
    queue_pixel(10, 11, 12);
    queue_pixel(128, 128, 128);
    queue_pixel(170, 85, 170);
    queue_pixel(255, 0, 1);
    queue_pixel(0, 1, 255);
    queue_pixel(85, 170, 85);
    queue_pixel(20, 0, 20);

    // Random pixels, some biased towards dark and saturated colours.
    for (int i = 0; i < 1030; i++) begin
      sel = $urandom_range(3);
      if (sel == 0)
        queue_pixel($urandom_range(24), $urandom_range(24), $urandom_range(24));
      else if (sel == 1)
        queue_pixel($urandom_range(1) * 255, $urandom_range(1) * 255, $urandom_range(255));
      else
        queue_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    while (pending_pixels.size() > 0 || pixel_valid || expected_lab.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
